FILE: hdl/box_sum_3x3_stream_top_assert.svh
// assertion macros shared by the box sum block
`ifndef BOX_SUM_3X3_STREAM_TOP_ASSERT_SVH
`define BOX_SUM_3X3_STREAM_TOP_ASSERT_SVH

// condition in this cycle demands a consequence in the same cycle
`define BSS_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("box sum check failed");

// condition in this cycle demands a consequence in the next cycle
`define BSS_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("box sum check failed");

`endif

FILE: hdl/bss_pkg.sv
`default_nettype none

package bss_pkg;

   localparam int MaxWidthDefault   = 1024;
   localparam int SampleBitsDefault = 16;

   localparam int RowWidthBits  = 11;
   localparam int WindowBits    = 20;
   localparam int CsrDataBits   = 32;
   localparam int CsrAddrBits   = 3;
   localparam int MinWidth      = 3;

   localparam logic [RowWidthBits-1:0] RowWidthReset = RowWidthBits'(MinWidth);

   // register index, taken from the word address
   localparam logic RegRowWidth = 1'b0;

   // line store control from the window pipeline
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } bss_mem_ctl_type;

endpackage

`default_nettype wire

FILE: hdl/bss_if.sv
`default_nettype none

interface bss_req_if #(
   parameter int SAMPLE_BITS = bss_pkg::SampleBitsDefault
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          frame_start;

   modport source (output valid, output sample, output frame_start, input ready);
   modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface bss_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [bss_pkg::WindowBits-1:0] window_sum;
   logic                                  row_last;

   modport source (output valid, output window_sum, output row_last, input ready);
   modport sink   (input valid, input window_sum, input row_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/box_sum_3x3_stream_top.sv
// 3x3 box sum over a raster stream of signed samples
//
// req_ch carries one sample per item in row-major order, with frame_start
// on the first sample of a matrix; rsp_ch carries window_sum and row_last.
// both are valid/ready channels, an item moves when valid and ready are high.
// row_width is written through the csr_ port (byte address 0); the user
// must write it only while idle, the block does not enforce this; values
// outside 3..MAX_WIDTH are clamped. one result per sample whose 3x3 window
// fits; other samples give none. a sample and its line store read are
// registered at the edge that accepts it; its column sums then go through
// the cell row into the rsp register when the window stage moves on.
// throughput: one item per cycle while the receiver takes results, with
// the two column cells shifting once per item.
// when the receiver stalls the output register holds its result; the window
// stage takes items until it holds one with a sum, then req_ch.ready drops.
// reset clears position, row count and the window and output valid flags;
// row_width returns to 3. line stores and cells stay, a new frame fills them.
`default_nettype none
`include "box_sum_3x3_stream_top_assert.svh"

module box_sum_3x3_stream_top
   import bss_pkg::*;
#(
   parameter int MAX_WIDTH   = MaxWidthDefault,
   parameter int SAMPLE_BITS = SampleBitsDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bss_req_if.sink                     req_ch,
   bss_rsp_if.source                   rsp_ch,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CsrAddrBits-1:0] csr_paddr,
   input  wire logic [CsrDataBits-1:0] csr_pwdata,
   output logic [CsrDataBits-1:0]      csr_prdata,
   output logic                        csr_pready
);

   localparam int AddrBits = $clog2(MAX_WIDTH);
   localparam int ColBits  = SAMPLE_BITS + 2;
   localparam int SumBits  = SAMPLE_BITS + 4;

   // ---------------- configuration ----------------
   logic [RowWidthBits-1:0] row_width_ff, row_width_in;
   logic [AddrBits-1:0]     last_col_ff, last_col_in;
   logic                    csr_write;
   logic [RowWidthBits-1:0] wr_width;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CsrAddrBits-1] == RegRowWidth);
   assign wr_width   = csr_pwdata[RowWidthBits-1:0];

   // clamp once at write time, keep the last column index
   always_comb begin
      row_width_in = row_width_ff;
      last_col_in  = last_col_ff;
      if (csr_write) begin
         row_width_in = wr_width;
         if ({21'd0, wr_width} < 32'(MinWidth)) begin
            last_col_in = AddrBits'(MinWidth - 1);
         end else if ({21'd0, wr_width} > 32'(MAX_WIDTH)) begin
            last_col_in = AddrBits'(MAX_WIDTH - 1);
         end else begin
            last_col_in = AddrBits'(wr_width - RowWidthBits'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= RowWidthReset;
         last_col_ff  <= AddrBits'(MinWidth - 1);
      end else begin
         row_width_ff <= row_width_in;
         last_col_ff  <= last_col_in;
      end
   end

   assign csr_prdata = (csr_paddr[CsrAddrBits-1] == RegRowWidth)
                       ? CsrDataBits'(row_width_ff) : '0;

   // ---------------- position tracking, accept stage ----------------
   logic [AddrBits-1:0] pos_ff, pos_in;
   logic [1:0]          rows_ff, rows_in;
   logic [AddrBits-1:0] pos_eff, col_idx;
   logic [1:0]          rows_eff;
   logic                is_last, will_produce;
   logic                accept;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_move;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [AddrBits-1:0]           s1_col_ff;
   logic                          s1_last_ff;
   logic                          s1_prod_ff;

   logic                          out_valid_ff, out_valid_in;
   logic signed [WindowBits-1:0]  out_sum_ff;
   logic                          out_last_ff;

   assign req_ch.ready = !s1_valid_ff || s1_move;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      pos_eff  = req_ch.frame_start ? '0 : pos_ff;
      rows_eff = req_ch.frame_start ? 2'd0 : rows_ff;
      col_idx  = (pos_eff > last_col_ff) ? last_col_ff : pos_eff;
      is_last  = (col_idx == last_col_ff);
      will_produce = (rows_eff == 2'd2) && (col_idx >= AddrBits'(2));
   end

   always_comb begin
      pos_in  = pos_ff;
      rows_in = rows_ff;
      if (accept) begin
         if (is_last) begin
            pos_in  = '0;
            rows_in = (rows_eff == 2'd2) ? rows_eff : rows_eff + 2'd1;
         end else begin
            pos_in  = col_idx + AddrBits'(1);
            rows_in = rows_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         rows_ff <= 2'd0;
      end else begin
         pos_ff  <= pos_in;
         rows_ff <= rows_in;
      end
   end

   // ---------------- window stage ----------------
   assign s1_move     = s1_valid_ff && (!s1_prod_ff || !out_valid_ff || rsp_ch.ready);
   assign s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_ch.sample;
         s1_col_ff    <= col_idx;
         s1_last_ff   <= is_last;
         s1_prod_ff   <= will_produce;
      end
   end

   // line stores: read on accept, write back when the window stage moves on
   bss_mem_ctl_type               mem_ctl;
   logic signed [SAMPLE_BITS-1:0] top_smp, mid_smp;

   assign mem_ctl.rd_en = accept;
   assign mem_ctl.wr_en = s1_move;

   bss_line_store #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_line_store (
      .clock     (clock),
      .ctl       (mem_ctl),
      .rd_addr   (col_idx),
      .wr_addr   (s1_col_ff),
      .wr_upper  (mid_smp),
      .wr_middle (s1_sample_ff),
      .rd_upper  (top_smp),
      .rd_middle (mid_smp)
   );

   // current column, then two cells holding the previous columns
   logic signed [ColBits-1:0] col_sum;
   logic signed [ColBits-1:0] cell0_col, cell1_col;
   logic signed [SumBits-1:0] part0, part1;

   assign col_sum = ColBits'(top_smp) + ColBits'(mid_smp) + ColBits'(s1_sample_ff);

   bss_col_cell #(
      .COL_BITS  (ColBits),
      .PART_BITS (SumBits)
   ) u_cell0 (
      .clock    (clock),
      .shift    (s1_move),
      .col_in   (col_sum),
      .part_in  (SumBits'(col_sum)),
      .col_out  (cell0_col),
      .part_out (part0)
   );

   bss_col_cell #(
      .COL_BITS  (ColBits),
      .PART_BITS (SumBits)
   ) u_cell1 (
      .clock    (clock),
      .shift    (s1_move),
      .col_in   (cell0_col),
      .part_in  (part0),
      .col_out  (cell1_col),
      .part_out (part1)
   );

   // ---------------- output register ----------------
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_move && s1_prod_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_prod_ff) begin
         out_sum_ff  <= WindowBits'(part1);
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.window_sum = out_sum_ff;
   assign rsp_ch.row_last   = out_last_ff;

   // ---------------- checks ----------------
   // a new item only enters when the window stage is free or leaving
   `BSS_ASSERT_SAME(a_accept_free, clock, reset, accept, !s1_valid_ff || s1_move)
   // a sum leaving the window stage lands in the output register
   `BSS_ASSERT_NEXT(a_sum_lands, clock, reset, s1_move && s1_prod_ff, out_valid_ff)
   // a stalled window stage keeps its item and column
   `BSS_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !s1_move,
                    s1_valid_ff && $stable(s1_col_ff))
   // no cell shift without an item in the window stage
   `BSS_ASSERT_SAME(a_shift_item, clock, reset, s1_move, s1_valid_ff)

endmodule

`default_nettype wire

FILE: hdl/bss_col_cell.sv
`default_nettype none

module bss_col_cell
   import bss_pkg::*;
#(
   parameter int COL_BITS  = SampleBitsDefault + 2,
   parameter int PART_BITS = SampleBitsDefault + 4
) (
   input  wire logic                        clock,
   input  wire logic                        shift,
   input  wire logic signed [COL_BITS-1:0]  col_in,
   input  wire logic signed [PART_BITS-1:0] part_in,
   output logic signed [COL_BITS-1:0]       col_out,
   output logic signed [PART_BITS-1:0]      part_out
);

   logic signed [COL_BITS-1:0] col_ff;
   logic signed [COL_BITS-1:0] col_in_w;

   assign col_in_w = shift ? col_in : col_ff;

   always_ff @(posedge clock) begin
      col_ff <= col_in_w;
   end

   // add the held column to the partial sum passing along the row
   assign part_out = part_in + PART_BITS'(col_ff);
   assign col_out  = col_ff;

endmodule

`default_nettype wire

FILE: hdl/bss_line_store.sv
`default_nettype none

module bss_line_store
   import bss_pkg::*;
#(
   parameter int MAX_WIDTH   = MaxWidthDefault,
   parameter int SAMPLE_BITS = SampleBitsDefault,
   localparam int AddrBits   = $clog2(MAX_WIDTH)
) (
   input  wire logic                          clock,
   input  wire bss_mem_ctl_type               ctl,
   input  wire logic [AddrBits-1:0]           rd_addr,
   input  wire logic [AddrBits-1:0]           wr_addr,
   input  wire logic signed [SAMPLE_BITS-1:0] wr_upper,
   input  wire logic signed [SAMPLE_BITS-1:0] wr_middle,
   output logic signed [SAMPLE_BITS-1:0]      rd_upper,
   output logic signed [SAMPLE_BITS-1:0]      rd_middle
);

   logic signed [SAMPLE_BITS-1:0] upper_mem  [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] middle_mem [MAX_WIDTH];

   logic signed [SAMPLE_BITS-1:0] rd_upper_ff;
   logic signed [SAMPLE_BITS-1:0] rd_middle_ff;
   logic signed [SAMPLE_BITS-1:0] fwd_upper_ff;
   logic signed [SAMPLE_BITS-1:0] fwd_middle_ff;
   logic                          fwd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         upper_mem[wr_addr]  <= wr_upper;
         middle_mem[wr_addr] <= wr_middle;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_upper_ff  <= upper_mem[rd_addr];
         rd_middle_ff <= middle_mem[rd_addr];
      end
   end

   // same address written in the read cycle: take the new data
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         fwd_ff        <= ctl.wr_en && (wr_addr == rd_addr);
         fwd_upper_ff  <= wr_upper;
         fwd_middle_ff <= wr_middle;
      end
   end

   assign rd_upper  = fwd_ff ? fwd_upper_ff  : rd_upper_ff;
   assign rd_middle = fwd_ff ? fwd_middle_ff : rd_middle_ff;

endmodule

`default_nettype wire

FILE: bench/box_sum_3x3_stream_top_tb.sv
`timescale 1ns / 100ps

typedef logic signed [bss_pkg::SampleBitsDefault-1:0] sample_type;

typedef struct packed {
   logic signed [bss_pkg::WindowBits-1:0] window_sum;
   logic                                  row_last;
} box_sum_type;

// predicts the window sums of the block and checks what comes out
class box_sum_board;
   sample_type                        upper_row [bss_pkg::MaxWidthDefault];
   sample_type                        middle_row [bss_pkg::MaxWidthDefault];
   sample_type                        window_cols [6];
   int unsigned                       column;
   int unsigned                       rows_done;
   logic [bss_pkg::RowWidthBits-1:0]  width_reg;
   box_sum_type                       pending_sums [$];
   int unsigned                       sums_checked;
   int unsigned                       mismatches;

   function new();
      foreach (upper_row[i]) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      foreach (window_cols[k]) window_cols[k] = '0;
      column       = 0;
      rows_done    = 0;
      width_reg    = bss_pkg::RowWidthReset;
      sums_checked = 0;
      mismatches   = 0;
   endfunction

   function void set_width(logic [bss_pkg::RowWidthBits-1:0] value);
      width_reg = value;
   endfunction

   // width in use, after clamping
   function int unsigned row_span();
      if (width_reg < bss_pkg::MinWidth) return bss_pkg::MinWidth;
      if (width_reg > bss_pkg::MaxWidthDefault) return bss_pkg::MaxWidthDefault;
      return width_reg;
   endfunction

   function void take_sample(sample_type s, logic frame_start);
      int unsigned span;
      int unsigned c;
      sample_type  top;
      sample_type  mid;
      logic        last;
      int          acc;
      box_sum_type r;
      span = row_span();
      if (frame_start) begin
         column    = 0;
         rows_done = 0;
      end
      if (column > span - 1) column = span - 1;
      c    = column;
      last = (c == span - 1);
      top  = upper_row[c];
      mid  = middle_row[c];
      if (rows_done >= 2 && c >= 2) begin
         acc = int'(top) + int'(mid) + int'(s);
         foreach (window_cols[k]) acc += int'(window_cols[k]);
         r.window_sum = acc[bss_pkg::WindowBits-1:0];
         r.row_last   = last;
         pending_sums.push_back(r);
      end
      window_cols[3] = window_cols[0];
      window_cols[4] = window_cols[1];
      window_cols[5] = window_cols[2];
      window_cols[0] = top;
      window_cols[1] = mid;
      window_cols[2] = s;
      upper_row[c]   = mid;
      middle_row[c]  = s;
      if (last) begin
         column = 0;
         if (rows_done < 2) rows_done++;
      end else begin
         column = c + 1;
      end
   endfunction

   task report_mismatch(string what);
      $display("mismatch on sum %0d: %s", sums_checked, what);
      mismatches++;
   endtask

   task match_sum(logic signed [bss_pkg::WindowBits-1:0] sum, logic last);
      box_sum_type want;
      if (pending_sums.size() == 0) begin
         report_mismatch($sformatf("unexpected sum %0d row_last %0b", sum, last));
         return;
      end
      want = pending_sums.pop_front();
      if (sum !== want.window_sum)
         report_mismatch($sformatf("window_sum %0d, want %0d", sum, want.window_sum));
      if (last !== want.row_last)
         report_mismatch($sformatf("row_last %0b, want %0b", last, want.row_last));
      sums_checked++;
   endtask
endclass

module box_sum_3x3_stream_top_tb;
   import bss_pkg::*;

   localparam int          HalfPeriod   = 5;
   localparam int          ResetCycles  = 7;
   // result passes the window stage, then a held output register
   localparam int          SettleCycles = 8;
   localparam int          MaxWait      = 8;
   // random phase share of the run, the directed part adds under a hundred
   localparam int          RandomItems  = 560;
   localparam int unsigned CycleLimit   = 600000;
   localparam sample_type  MaxSample    = sample_type'(32767);
   localparam sample_type  MinSample    = sample_type'(-32768);
   localparam logic [CsrAddrBits-1:0] RowWidthAddr = CsrAddrBits'(4 * int'(RegRowWidth));

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CsrAddrBits-1:0] csr_paddr;
   logic [CsrDataBits-1:0] csr_pwdata;
   logic [CsrDataBits-1:0] csr_prdata;
   logic                   csr_pready;

   bss_req_if #(.SAMPLE_BITS(SampleBitsDefault)) req_ch ();
   bss_rsp_if                                    rsp_ch ();

   box_sum_board board;
   int unsigned  cycle_count;
   int unsigned  random_fed;
   // calm stretches: no idling on that side until the next toggle
   bit           feed_calm;
   bit           drain_calm;

   box_sum_3x3_stream_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(HalfPeriod) clock = ~clock;

   // cycles to idle before the next item, now and then toggling a calm stretch
   function automatic int unsigned draw_wait(inout bit calm);
      if ($urandom_range(0, 31) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, MaxWait);
   endfunction

   // extremes turn up often so that large sums of either sign occur
   function automatic sample_type pick_sample();
      case ($urandom_range(0, 7))
         0: begin
            return MaxSample;
         end
         1: begin
            return MinSample;
         end
         default: begin
            return sample_type'($urandom);
         end
      endcase
   endfunction

   // one sample through the request channel; valid stays high for a following item
   task automatic feed(input sample_type s, input logic frame_start);
      int unsigned gap;
      gap = draw_wait(feed_calm);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.sample      <= s;
      req_ch.frame_start <= frame_start;
      do @(posedge clock); while (!req_ch.ready);
      board.take_sample(s, frame_start);
      random_fed++;
   endtask

   // setup cycle, then access cycle; the register takes the value where pready is high
   task automatic write_width(input logic [CsrDataBits-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= RowWidthAddr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_width(value[RowWidthBits-1:0]);
   endtask

   // stop feeding, let every expected sum arrive, then let the pipeline empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.pending_sums.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // whole rows of random samples plus a partial tail; a rare frame start
   // in the middle breaks the frame
   task automatic feed_frame(input int unsigned span, input int unsigned rows,
                             input int unsigned tail, input logic lead_start);
      for (int unsigned n = 0; n < rows * span + tail; n++)
         feed(pick_sample(), (n == 0) ? lead_start : ($urandom_range(0, 63) == 0));
   endtask

   // result side: random stalls, every accepted item checked against the board
   task automatic drain_results();
      int unsigned stall;
      forever begin
         stall = draw_wait(drain_calm);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         board.match_sum(rsp_ch.window_sum, rsp_ch.row_last);
      end
   endtask

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** box_sum_3x3_stream_top: FAILED **");
      $finish;
   end

   initial begin
      int unsigned                prev_span;
      int unsigned                frames;
      int unsigned                rows;
      int unsigned                tail;
      logic [RowWidthBits-1:0]    width_pick;
      logic                       lead_start;

      board = new();
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.sample      <= '0;
      req_ch.frame_start <= 1'b0;
      rsp_ch.ready       <= 1'b0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      fork
         drain_results();
      join_none

      // reset width of three: a frame of maxima gives the largest sum
      for (int i = 0; i < 9; i++) feed(MaxSample, i == 0);
      settle();
      // width below the minimum clamps to three; frame of minima, smallest sum
      write_width(32'd2);
      for (int i = 0; i < 9; i++) feed(MinSample, i == 0);
      settle();
      // width four: two rows and the first three samples of the third
      write_width(32'd4);
      for (int i = 0; i < 11; i++) feed(pick_sample(), i == 0);
      settle();
      // narrowing mid-frame, upper data bits ignored: position three is past
      // the new last column, so the next sample closes the row there
      write_width(32'hFFFF_F803);
      for (int i = 0; i < 4; i++) feed(pick_sample(), 1'b0);
      settle();

      // widest rows: the position runs on well past the narrow widths
      write_width(32'd1024);
      for (int i = 0; i < 40; i++) feed(pick_sample(), i == 0);
      settle();
      // all eleven bits set clamps to the widest row, frame carries on
      write_width(32'd2047);
      for (int i = 0; i < 12; i++) feed(pick_sample(), 1'b0);
      settle();

      // random phases: mostly narrow rows, now and then clamped or wider ones;
      // a wider setting always starts a new frame so no stale line entry is read
      random_fed = 0;
      while (random_fed < RandomItems) begin
         case ($urandom_range(0, 9))
            0: begin
               width_pick = RowWidthBits'($urandom_range(0, 2));
            end
            1: begin
               width_pick = RowWidthBits'($urandom_range(17, 48));
            end
            default: begin
               width_pick = RowWidthBits'($urandom_range(3, 16));
            end
         endcase
         prev_span = board.row_span();
         write_width(($urandom & ~32'h7FF) | CsrDataBits'(width_pick));
         if (board.row_span() > prev_span) lead_start = 1'b1;
         else lead_start = 1'($urandom_range(0, 1));
         frames = $urandom_range(1, 3);
         for (int unsigned f = 0; f < frames; f++) begin
            rows = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
            tail = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, board.row_span() - 1);
            feed_frame(board.row_span(), rows, tail, (f == 0) ? lead_start : 1'b1);
         end
         settle();
      end

      if (board.pending_sums.size() != 0)
         board.report_mismatch($sformatf("%0d sums never came", board.pending_sums.size()));

      if (board.mismatches == 0) begin
         $display("** box_sum_3x3_stream_top: PASSED **");
      end else begin
         $display("** box_sum_3x3_stream_top: FAILED **");
      end
      $finish;
   end

endmodule

FILE: box_sum_3x3_stream_top.f
+incdir+hdl
hdl/bss_pkg.sv
hdl/bss_if.sv
hdl/bss_col_cell.sv
hdl/bss_line_store.sv
hdl/box_sum_3x3_stream_top.sv
bench/box_sum_3x3_stream_top_tb.sv
